// ===== src/cet_pkg.sv =====
package cet_pkg;

  // Coordinate format: signed fixed point, Q4.28 by default
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 28;
  localparam int COUNT_WIDTH = 16;

  // Full-width product and the accumulator that adds c to it
  localparam int PROD_W = 2 * COORD_WIDTH;
  localparam int ACC_W  = PROD_W + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;

  // Saturation limits of the coordinate format, at accumulator width
  localparam acc_t SAT_HI = {{(ACC_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam acc_t SAT_LO = ~SAT_HI;

  // |z|^2 escape bound: 4.0 in the squared format (2*FRAC_BITS fraction bits)
  localparam logic [PROD_W:0] ESC_LIMIT = {{PROD_W{1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

  localparam count_t LIMIT_RESET = COUNT_WIDTH'(256);

  // Clamp an accumulator value to the coordinate range
  function automatic coord_t sat_coord(input acc_t v);
    coord_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[COORD_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/cet_mult.sv =====
module cet_mult
  import cet_pkg::*;
(
  input  logic   clk,
  input  coord_t a,
  input  coord_t b,
  output prod_t  p
);

  prod_t a_x;
  prod_t b_x;

  // sign-extend operands to full product width
  assign a_x = PROD_W'(a);
  assign b_x = PROD_W'(b);

  // shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    p <= a_x * b_x;
  end

endmodule

// ===== src/cet_znext.sv =====
module cet_znext
  import cet_pkg::*;
(
  input  prod_t  rr,
  input  prod_t  ii,
  input  prod_t  ri,
  input  coord_t c_re,
  input  coord_t c_im,
  output coord_t z_re_next,
  output coord_t z_im_next
);

  acc_t cre_x;
  acc_t cim_x;
  acc_t re_sum;
  acc_t im_sum;
  acc_t re_shr;
  acc_t im_shr;

  // c aligned to the product format; imaginary side carries the factor 2
  assign cre_x = ACC_W'(c_re) <<< FRAC_BITS;
  assign cim_x = ACC_W'(c_im) <<< (FRAC_BITS - 1);

  // re = zr^2 - zi^2 + c_re, im = 2*zr*zi + c_im
  assign re_sum = ACC_W'(rr) - ACC_W'(ii) + cre_x;
  assign im_sum = ACC_W'(ri) + cim_x;

  // floor back to coordinate scale, then clamp
  assign re_shr = re_sum >>> FRAC_BITS;
  assign im_shr = im_sum >>> (FRAC_BITS - 1);

  assign z_re_next = sat_coord(re_shr);
  assign z_im_next = sat_coord(im_shr);

endmodule

// ===== src/complex_escape_time_iterator.sv =====
// Channel  | Dir | Beat contents (low bit first)
// s_axis   | in  | tdata: z_re_start, z_im_start, c_re, c_im (32 bits each)
// m_axis   | out | tdata: iteration_count (16 bits)
// cfg      | in  | cfg_wdata: max_iterations (16 bits), written when cfg_we is high
//
// Each point runs from input beat to result through n updates, n being the number of
// updates performed; each update is three passes through the one 32x32 multiplier
// (S_RR, S_II, S_RI) plus the add and clamp in S_UPD. Input ready only while idle.
// A finished result waits in the output register; a next point is accepted meanwhile.
// Reset (rst, synchronous) sets max_iterations to 256 and empties the output.
module complex_escape_time_iterator
  import cet_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // z_re_start [31:0], z_im_start [63:32], c_re [95:64], c_im [127:96]
  input  logic [4*COORD_WIDTH-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // iteration_count [15:0]
  output logic [COUNT_WIDTH-1:0]   m_axis_tdata,
  input  logic                     cfg_we,
  input  logic [COUNT_WIDTH-1:0]   cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RR   = 3'd1;
  localparam logic [2:0] S_II   = 3'd2;
  localparam logic [2:0] S_RI   = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  count_t count_limit;
  count_t count;
  logic   updated;
  coord_t zr;
  coord_t zi;
  coord_t cre;
  coord_t cim;
  prod_t  rr;
  prod_t  ii;

  coord_t           mul_a;
  coord_t           mul_b;
  prod_t            prod;
  coord_t           zr_new;
  coord_t           zi_new;
  logic [PROD_W:0]  mag_sq;
  logic             escaped;
  logic [COUNT_WIDTH:0] cnt_inc;
  logic             hit_max;
  logic             out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      count_limit <= cfg_wdata;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = zr;
    mul_b = zr;
    case (state)
      S_II: begin
        mul_a = zi;
        mul_b = zi;
      end
      S_RI: begin
        mul_a = zr;
        mul_b = zi;
      end
      default: begin
        mul_a = zr;
        mul_b = zr;
      end
    endcase
  end

  cet_mult u_mult (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // next z from zr^2 (rr), zi^2 (ii) and zr*zi (product in S_UPD)
  cet_znext u_znext (
    .rr        (rr),
    .ii        (ii),
    .ri        (prod),
    .c_re      (cre),
    .c_im      (cim),
    .z_re_next (zr_new),
    .z_im_next (zi_new)
  );

  // escape test on the squares of the last updated z (zi^2 arrives in S_RI)
  assign mag_sq  = {1'b0, rr} + {1'b0, prod};
  assign escaped = updated && (mag_sq > ESC_LIMIT);
  assign cnt_inc = {1'b0, count} + {{COUNT_WIDTH{1'b0}}, 1'b1};
  assign hit_max = updated ? (cnt_inc == {1'b0, count_limit}) : (count_limit == '0);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_RR;
      end
      S_RR:   state_next = S_II;
      S_II:   state_next = S_RI;
      S_RI: begin
        if (escaped || hit_max) state_next = S_HOLD;
        else state_next = S_UPD;
      end
      S_UPD:  state_next = S_RR;
      S_HOLD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          zr      <= s_axis_tdata[COORD_WIDTH-1:0];
          zi      <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
          cre     <= s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
          cim     <= s_axis_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];
          count   <= '0;
          updated <= 1'b0;
        end
      end
      S_II: rr <= prod;
      S_RI: begin
        ii <= prod;
        if (updated && !escaped) count <= cnt_inc[COUNT_WIDTH-1:0];
      end
      S_UPD: begin
        zr      <= zr_new;
        zi      <= zi_new;
        updated <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_HOLD && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HOLD && out_free) begin
      m_axis_tdata <= count;
    end
  end

endmodule
